// ===== src/bvpr_pkg.sv =====
// Package for the Bloch voxel precession/relaxation pipeline.
// Holds widths, config register indexes, the config struct and the
// elaboration-time ROM builders (rotation and half-power constants).
package bvpr_pkg;

  localparam int MAG_BITS  = 24;
  localparam int TRIG_FRAC = 30;
  localparam int E_FRAC    = 24;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam int EXP_CUTOFF = 40;

  localparam logic [2:0] REG_GRAD_X  = 3'd0;
  localparam logic [2:0] REG_GRAD_Y  = 3'd1;
  localparam logic [2:0] REG_GRAD_Z  = 3'd2;
  localparam logic [2:0] REG_BASE    = 3'd3;
  localparam logic [2:0] REG_SCALE   = 3'd4;
  localparam logic [2:0] REG_OFREQ   = 3'd5;
  localparam logic [2:0] REG_DELAY   = 3'd6;

  typedef struct packed {
    logic [31:0] grad_x;
    logic [31:0] grad_y;
    logic [31:0] grad_z;
    logic [31:0] base;
    logic [31:0] scale;
    logic [31:0] ofreq;
    logic [23:0] delay;
  } cfg_t;

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r  = '0;
    xx = x;
    b  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // cos/sin of 2^-k turn, Q1.30, by half-angle recursion
  function automatic logic [63:0] rot_cs(int k, bit want_sin);
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] ck;
    logic [63:0] sk;
    c  = '0;
    s  = 64'd1 << TRIG_FRAC;
    ck = '0;
    sk = '0;
    for (int m = 3; m <= 32; m++) begin
      if (m <= k) begin
        ck = isqrt64(((64'd1 << TRIG_FRAC) + c) << 29);
        sk = udiv64((s << 30) + ck, ck << 1);
        c  = ck;
        s  = sk;
      end
    end
    return want_sin ? sk : ck;
  endfunction

  // 2^(-2^-k), Q0.30
  function automatic logic [63:0] half_pow(int k);
    logic [63:0] h;
    h = 64'd1 << 29;
    for (int m = 1; m <= 24; m++) begin
      if (m <= k) h = isqrt64(h << 30);
    end
    return h;
  endfunction

endpackage

// ===== src/bvpr_phase.sv =====
// Field and phase stages: three registered steps from voxel item to Q0.32 phase.
// Depends on bvpr_pkg.
module bvpr_phase import bvpr_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  cfg_t        cfg_i,
  input  logic [7:0]  voxel_x_i,
  input  logic [7:0]  voxel_y_i,
  input  logic [7:0]  voxel_z_i,
  input  logic [31:0] field_offset_i,
  output logic [31:0] phase_o
);

  logic [31:0] field_d, field_q;
  logic [31:0] prod_d, prod_q;
  logic [31:0] phase_d, phase_q;
  logic [31:0] diff;

  always_comb begin
    field_d = 32'(cfg_i.grad_x * {24'd0, voxel_x_i}) + 32'(cfg_i.grad_y * {24'd0, voxel_y_i})
            + 32'(cfg_i.grad_z * {24'd0, voxel_z_i}) + cfg_i.base + field_offset_i;
    prod_d  = 32'(cfg_i.scale * field_q);
    diff    = prod_q - cfg_i.ofreq;
    phase_d = 32'(diff * {8'd0, cfg_i.delay});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      field_q <= field_d;
      prod_q  <= prod_d;
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

// ===== src/bvpr_rot.sv =====
// Turn-to-cos/sin pipeline: quarter-turn select then 30 conditional ROM rotations.
// Depends on bvpr_pkg.
module bvpr_rot import bvpr_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int NSTG = 30;
  localparam logic signed [31:0] ONE = 32'sd1 << TRIG_FRAC;

  logic signed [31:0] c_q  [NSTG];
  logic signed [31:0] s_q  [NSTG];
  logic        [29:0] ph_q [NSTG];
  logic signed [31:0] c0, s0;

  always_comb begin
    unique case (phase_i[31:30])
      2'd0:    begin c0 = ONE;  s0 = '0;   end
      2'd1:    begin c0 = '0;   s0 = ONE;  end
      2'd2:    begin c0 = -ONE; s0 = '0;   end
      default: begin c0 = '0;   s0 = -ONE; end
    endcase
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    localparam logic signed [31:0] RC = 32'(rot_cs(3 + i, 1'b0));
    localparam logic signed [31:0] RS = 32'(rot_cs(3 + i, 1'b1));
    logic signed [31:0] c_in, s_in, c_d, s_d;
    logic        [29:0] ph_in;
    logic signed [63:0] pcc, pss, pcs, psc, sum_c, sum_s;

    if (i == 0) begin : g_first
      assign c_in  = c0;
      assign s_in  = s0;
      assign ph_in = phase_i[29:0];
    end else begin : g_next
      assign c_in  = c_q[i-1];
      assign s_in  = s_q[i-1];
      assign ph_in = ph_q[i-1];
    end

    always_comb begin
      pcc   = 64'(c_in) * 64'(RC);
      pss   = 64'(s_in) * 64'(RS);
      pcs   = 64'(c_in) * 64'(RS);
      psc   = 64'(s_in) * 64'(RC);
      sum_c = (pcc - pss + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      sum_s = (pcs + psc + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      if (ph_in[29-i]) begin
        c_d = sum_c[31:0];
        s_d = sum_s[31:0];
      end else begin
        c_d = c_in;
        s_d = s_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_q[i]  <= c_d;
        s_q[i]  <= s_d;
        ph_q[i] <= ph_in;
      end
    end
  end

  assign cos_o = c_q[NSTG-1];
  assign sin_o = s_q[NSTG-1];

endmodule

// ===== src/bvpr_div.sv =====
// Restoring divider, one quotient bit per stage: r = floor(delay*2^24 / t).
// Flags the exponent cut-off (t zero or delay >= 40*t). Depends on bvpr_pkg.
module bvpr_div import bvpr_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [23:0] delay_i,
  input  logic [23:0] t_i,
  output logic [29:0] quo_o,
  output logic        cut_o
);

  localparam int NSTG = 30;

  logic [23:0] rem_q [NSTG];
  logic [23:0] t_q   [NSTG];
  logic [29:0] quo_q [NSTG];
  logic        cut_q [NSTG];
  logic        cut0;

  assign cut0 = (t_i == '0) || ({6'd0, delay_i} >= 30'(t_i) * 30'(EXP_CUTOFF));

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    localparam int B = 29 - i;
    logic [23:0] rem_in, t_in, rem_d;
    logic [29:0] quo_in, quo_d;
    logic        cut_in, nbit;
    logic [24:0] p, pd;

    if (i == 0) begin : g_first
      assign rem_in = {6'd0, delay_i[23:6]};
      assign t_in   = t_i;
      assign quo_in = '0;
      assign cut_in = cut0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign t_in   = t_q[i-1];
      assign quo_in = quo_q[i-1];
      assign cut_in = cut_q[i-1];
    end

    if (B >= E_FRAC) begin : g_dbit
      assign nbit = delay_i[B-E_FRAC];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end

    always_comb begin
      p     = {rem_in, nbit};
      pd    = p - {1'b0, t_in};
      quo_d = quo_in;
      if (p >= {1'b0, t_in}) begin
        rem_d    = pd[23:0];
        quo_d[B] = 1'b1;
      end else begin
        rem_d = p[23:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        t_q[i]   <= t_in;
        quo_q[i] <= quo_d;
        cut_q[i] <= cut_in;
      end
    end
  end

  assign quo_o = quo_q[NSTG-1];
  assign cut_o = cut_q[NSTG-1];

endmodule

// ===== src/bvpr_exp.sv =====
// exp(-r) in Q1.24: log2e scale, 24 conditional half-power steps, final shift.
// Depends on bvpr_pkg.
module bvpr_exp import bvpr_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [29:0] r_i,
  input  logic        cut_i,
  output logic [24:0] e_o
);

  localparam int NSTG = 24;

  logic [60:0] um;
  logic [29:0] u_q;
  logic        cut_a_q;
  logic [30:0] v_q   [NSTG];
  logic [29:0] u_s_q [NSTG];
  logic        cut_q [NSTG];
  logic [6:0]  sh;
  logic [63:0] rsum;
  logic [24:0] e_d, e_q;

  assign um = 61'(r_i) * 61'(LOG2E_Q30) + (61'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= um[59:30];
      cut_a_q <= cut_i;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    localparam logic [29:0] HP = 30'(half_pow(i + 1));
    logic [30:0] v_in, v_d;
    logic [29:0] u_in;
    logic        cut_in;
    logic [60:0] pm;

    if (i == 0) begin : g_first
      assign v_in   = 31'd1 << 30;
      assign u_in   = u_q;
      assign cut_in = cut_a_q;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign u_in   = u_s_q[i-1];
      assign cut_in = cut_q[i-1];
    end

    always_comb begin
      pm  = 61'(v_in) * 61'(HP) + (61'd1 << 29);
      v_d = u_in[E_FRAC-1-i] ? pm[60:30] : v_in;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[i]   <= v_d;
        u_s_q[i] <= u_in;
        cut_q[i] <= cut_in;
      end
    end
  end

  always_comb begin
    sh   = {1'b0, u_s_q[NSTG-1][29:24]} + 7'd6;
    rsum = ({33'd0, v_q[NSTG-1]} + (64'd1 << (sh - 7'd1))) >> sh;
    e_d  = cut_q[NSTG-1] ? '0 : rsum[24:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) e_q <= e_d;
  end

  assign e_o = e_q;

endmodule

// ===== src/bloch_voxel_precession_relax.sv =====
// Top level of the Bloch precession/relaxation pipeline: config registers,
// stall control, delay lines and the final rotate/scale/saturate stages.
// Depends on bvpr_pkg, bvpr_phase, bvpr_rot, bvpr_div, bvpr_exp.
//
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o + voxel fields      | item in
//  out     | out_valid_o/out_ready_i + new_mag_x/y/z   | item out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i          | register write
//
// 58 register stages; one item per cycle sustained while no output is held.
// The relaxation path sets the depth: 30 divider, 26 exponent and 2 output
// stages; the rotation path is padded to match.
// Reset clears valid bits and config registers only.
// A held output stalls every stage together; in_ready_o drops only then.
module bloch_voxel_precession_relax import bvpr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 voxel_x_i,
  input  logic [7:0]                 voxel_y_i,
  input  logic [7:0]                 voxel_z_i,
  input  logic signed [MAG_BITS-1:0] mag_x_i,
  input  logic signed [MAG_BITS-1:0] mag_y_i,
  input  logic signed [MAG_BITS-1:0] mag_z_i,
  input  logic [23:0]                t1_us_i,
  input  logic [23:0]                t2_us_i,
  input  logic [MAG_BITS-2:0]        density_i,
  input  logic [31:0]                field_offset_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [MAG_BITS-1:0] new_mag_x_o,
  output logic signed [MAG_BITS-1:0] new_mag_y_o,
  output logic signed [MAG_BITS-1:0] new_mag_z_o
);

  localparam int LAT     = 58;
  localparam int XY_DLY  = 33;
  localparam int Z_DLY   = 56;
  localparam int R_DLY   = 21;
  localparam int RW      = MAG_BITS + 3;
  localparam int PW      = MAG_BITS + 32;
  localparam int QW      = RW + 26;
  localparam int ZW      = MAG_BITS + 26;
  localparam logic signed [MAG_BITS+4:0] SAT_HI = (MAG_BITS+5)'((1 << (MAG_BITS-1)) - 1);
  localparam logic signed [MAG_BITS+4:0] SAT_LO = -(MAG_BITS+5)'(1 << (MAG_BITS-1));

  cfg_t cfg_q;
  logic en;
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRAD_X: cfg_q.grad_x <= cfg_wdata_i;
        REG_GRAD_Y: cfg_q.grad_y <= cfg_wdata_i;
        REG_GRAD_Z: cfg_q.grad_z <= cfg_wdata_i;
        REG_BASE:   cfg_q.base   <= cfg_wdata_i;
        REG_SCALE:  cfg_q.scale  <= cfg_wdata_i;
        REG_OFREQ:  cfg_q.ofreq  <= cfg_wdata_i;
        REG_DELAY:  cfg_q.delay  <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  assign en         = ~vld_q[LAT-1] | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic [31:0] phase;
  logic signed [31:0] cos_v, sin_v;
  logic [29:0] q1, q2;
  logic cut1, cut2;
  logic [24:0] e1, e2;

  bvpr_phase u_phase (
    .clk_i, .en_i(en), .cfg_i(cfg_q),
    .voxel_x_i, .voxel_y_i, .voxel_z_i, .field_offset_i,
    .phase_o(phase)
  );

  bvpr_rot u_rot (.clk_i, .en_i(en), .phase_i(phase), .cos_o(cos_v), .sin_o(sin_v));

  bvpr_div u_div1 (.clk_i, .en_i(en), .delay_i(cfg_q.delay), .t_i(t1_us_i),
                   .quo_o(q1), .cut_o(cut1));
  bvpr_div u_div2 (.clk_i, .en_i(en), .delay_i(cfg_q.delay), .t_i(t2_us_i),
                   .quo_o(q2), .cut_o(cut2));

  bvpr_exp u_exp1 (.clk_i, .en_i(en), .r_i(q1), .cut_i(cut1), .e_o(e1));
  bvpr_exp u_exp2 (.clk_i, .en_i(en), .r_i(q2), .cut_i(cut2), .e_o(e2));

  logic signed [MAG_BITS-1:0] mx_d [XY_DLY];
  logic signed [MAG_BITS-1:0] my_d [XY_DLY];
  logic signed [MAG_BITS-1:0] mz_d [Z_DLY];
  logic        [MAG_BITS-2:0] dn_d [Z_DLY];
  logic signed [RW-1:0]       rx_d [R_DLY];
  logic signed [RW-1:0]       ry_d [R_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_d[0] <= mag_x_i;
      my_d[0] <= mag_y_i;
      mz_d[0] <= mag_z_i;
      dn_d[0] <= density_i;
      for (int k = 1; k < XY_DLY; k++) begin
        mx_d[k] <= mx_d[k-1];
        my_d[k] <= my_d[k-1];
      end
      for (int k = 1; k < Z_DLY; k++) begin
        mz_d[k] <= mz_d[k-1];
        dn_d[k] <= dn_d[k-1];
      end
    end
  end

  // rotation of the transverse vector
  logic signed [PW-1:0] pcx_q, psy_q, pcy_q, psx_q;
  logic signed [PW:0]   sx, sy;
  logic signed [RW-1:0] rx_q, ry_q;

  assign sx = (PW+1)'(pcx_q) + (PW+1)'(psy_q) + ((PW+1)'(1) <<< (TRIG_FRAC - 1));
  assign sy = (PW+1)'(pcy_q) - (PW+1)'(psx_q) + ((PW+1)'(1) <<< (TRIG_FRAC - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      pcx_q <= PW'(cos_v) * PW'(mx_d[XY_DLY-1]);
      psy_q <= PW'(sin_v) * PW'(my_d[XY_DLY-1]);
      pcy_q <= PW'(cos_v) * PW'(my_d[XY_DLY-1]);
      psx_q <= PW'(sin_v) * PW'(mx_d[XY_DLY-1]);
      rx_q  <= RW'(sx >>> TRIG_FRAC);
      ry_q  <= RW'(sy >>> TRIG_FRAC);
      rx_d[0] <= rx_q;
      ry_d[0] <= ry_q;
      for (int k = 1; k < R_DLY; k++) begin
        rx_d[k] <= rx_d[k-1];
        ry_d[k] <= ry_d[k-1];
      end
    end
  end

  // relaxation scaling
  logic signed [25:0] e1s, e2s, one_m_e1;
  logic signed [MAG_BITS-1:0] dens_s;
  logic signed [QW-1:0] px_q, py_q;
  logic signed [ZW-1:0] z1_q, z2_q;
  logic signed [ZW:0]   zsum;
  logic signed [MAG_BITS+4:0] nx, ny, nz;
  logic signed [MAG_BITS-1:0] ox_q, oy_q, oz_q;

  assign e1s      = {1'b0, e1};
  assign e2s      = {1'b0, e2};
  assign one_m_e1 = (26'sd1 <<< E_FRAC) - e1s;
  assign dens_s   = {1'b0, dn_d[Z_DLY-1]};

  always_comb begin
    zsum = (ZW+1)'(z1_q) + (ZW+1)'(z2_q) + ((ZW+1)'(1) <<< (E_FRAC - 1));
    nx   = (MAG_BITS+5)'((px_q + (QW'(1) <<< (E_FRAC - 1))) >>> E_FRAC);
    ny   = (MAG_BITS+5)'((py_q + (QW'(1) <<< (E_FRAC - 1))) >>> E_FRAC);
    nz   = (MAG_BITS+5)'(zsum >>> E_FRAC);
  end

  function automatic logic signed [MAG_BITS-1:0] sat(logic signed [MAG_BITS+4:0] v);
    if (v > SAT_HI) return SAT_HI[MAG_BITS-1:0];
    if (v < SAT_LO) return SAT_LO[MAG_BITS-1:0];
    return v[MAG_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= QW'(rx_d[R_DLY-1]) * QW'(e2s);
      py_q <= QW'(ry_d[R_DLY-1]) * QW'(e2s);
      z1_q <= ZW'(e1s) * ZW'(mz_d[Z_DLY-1]);
      z2_q <= ZW'(dens_s) * ZW'(one_m_e1);
      ox_q <= sat(nx);
      oy_q <= sat(ny);
      oz_q <= sat(nz);
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign new_mag_x_o = ox_q;
  assign new_mag_y_o = oy_q;
  assign new_mag_z_o = oz_q;

endmodule
